// ----- design/pbu_pkg.sv -----
// Package for the pixel blend unit: action codes, payload types and arithmetic helpers.
package pbu_pkg;

   typedef enum logic [2:0] {
      ACT_MULTIPLY  = 3'd0,
      ACT_SCREEN    = 3'd1,
      ACT_SUBTRACT  = 3'd2,
      ACT_ADD       = 3'd3,
      ACT_OVERLAY   = 3'd4,
      ACT_INVERT    = 3'd5,
      ACT_GRAYSCALE = 3'd6,
      ACT_SEPIA     = 3'd7
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  a_red;
      logic [7:0]  a_green;
      logic [7:0]  a_blue;
      logic [7:0]  b_red;
      logic [7:0]  b_green;
      logic [7:0]  b_blue;
   } req_data_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
   } rsp_data_type;

   // sepia weights in thousandths
   localparam logic [9:0] SEPIA_RR = 10'd393;
   localparam logic [9:0] SEPIA_RG = 10'd769;
   localparam logic [9:0] SEPIA_RB = 10'd189;
   localparam logic [9:0] SEPIA_GR = 10'd349;
   localparam logic [9:0] SEPIA_GG = 10'd686;
   localparam logic [9:0] SEPIA_GB = 10'd168;
   localparam logic [9:0] SEPIA_BR = 10'd272;
   localparam logic [9:0] SEPIA_BG = 10'd534;
   localparam logic [9:0] SEPIA_BB = 10'd131;

   localparam logic [18:0] SEPIA_ROUND = 19'd500;
   localparam logic [18:0] SEPIA_SAT   = 19'd256000;   // 256 * 1000
   localparam logic [30:0] DIV125_RECIP = 31'd33555;   // ceil(2^22 / 125)
   localparam logic [19:0] DIV3_RECIP   = 20'd683;     // ceil(2^11 / 3)

   // round(p / 255), exact for p up to 65025
   function automatic logic [7:0] div255_round(input logic [16:0] p);
      logic [16:0] t;
      logic [16:0] s;
      t = p + 17'd128;
      s = t + (t >> 8);
      return s[15:8];
   endfunction

   // floor(n / 3) for n up to 767
   function automatic logic [7:0] div3(input logic [9:0] n);
      logic [19:0] prod;
      prod = 20'(n) * DIV3_RECIP;
      return prod[18:11];
   endfunction

   // min(255, floor((kr*r + kg*g + kb*b + 500) / 1000))
   function automatic logic [7:0] sepia_ch(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic [9:0] kr,
                                           input logic [9:0] kg, input logic [9:0] kb);
      logic [18:0] sum;
      logic [14:0] eighth;
      logic [30:0] prod;
      sum = 19'(kr) * 19'(r) + 19'(kg) * 19'(g) + 19'(kb) * 19'(b) + SEPIA_ROUND;
      eighth = sum[17:3];
      // divide by 1000 as a shift by 3 then a reciprocal multiply for 125
      prod = 31'(eighth) * DIV125_RECIP;
      if (sum >= SEPIA_SAT) begin
         return 8'hFF;
      end
      return prod[29:22];
   endfunction

   // per-channel blend; one 8x8 product shared by multiply, screen and overlay
   function automatic logic [7:0] blend_ch(input action_type act, input logic [7:0] x,
                                           input logic [7:0] y);
      logic        flip;
      logic [7:0]  xs;
      logic [7:0]  ys;
      logic [15:0] prod;
      logic [16:0] scaled;
      logic [7:0]  quot;
      logic [8:0]  total;
      logic [7:0]  res;
      flip = (act == ACT_SCREEN) || ((act == ACT_OVERLAY) && y[7]);
      xs = flip ? ~x : x;
      ys = flip ? ~y : y;
      prod = 16'(xs) * 16'(ys);
      scaled = (act == ACT_OVERLAY) ? {prod, 1'b0} : {1'b0, prod};
      quot = div255_round(scaled);
      total = {1'b0, x} + {1'b0, y};
      unique case (act)
         ACT_MULTIPLY:  res = quot;
         ACT_SCREEN:    res = ~quot;
         ACT_SUBTRACT:  res = (x > y) ? (x - y) : 8'd0;
         ACT_ADD:       res = total[8] ? 8'hFF : total[7:0];
         ACT_OVERLAY:   res = flip ? ~quot : quot;
         ACT_INVERT:    res = ~x;
         ACT_GRAYSCALE: res = ~x;
         ACT_SEPIA:     res = ~x;
         default:       res = ~x;
      endcase
      return res;
   endfunction

endpackage

// ----- design/pbu_if.sv -----
// Request and result channel interfaces of the pixel blend unit.
interface pbu_req_if;
   logic                 valid;
   logic                 ready;
   pbu_pkg::action_type  action;
   logic [7:0]           a_red;
   logic [7:0]           a_green;
   logic [7:0]           a_blue;
   logic [7:0]           b_red;
   logic [7:0]           b_green;
   logic [7:0]           b_blue;

   modport source (output valid, action, a_red, a_green, a_blue, b_red, b_green, b_blue,
                   input ready);
   modport sink   (input valid, action, a_red, a_green, a_blue, b_red, b_green, b_blue,
                   output ready);
endinterface

interface pbu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ----- design/pixel_blend_unit_top.sv -----
// Pixel blend unit top level: two-register pipeline around the blend arithmetic.
// Requests pass the input register, then the result register. Throughput: one request per cycle
// unless rsp_chan stalls; each register advances when the one after it frees up. The blend math
// (one 8x8 product per channel for blends, constant reciprocal multiplies) sits between the two
// registers. Reset (synchronous, active high) clears both valid flags; data is kept.
module pixel_blend_unit_top (
   input  logic             clock,
   input  logic             reset,
   pbu_req_if.sink          req_chan,
   pbu_rsp_if.source        rsp_chan
);

   // ---------------------------------------------------------------------------
   // Stage 1: input register
   // ---------------------------------------------------------------------------
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   pbu_pkg::req_data_type  s1_data_ff;
   pbu_pkg::req_data_type  s1_data_in;

   // Stage 2: result register
   logic                   s2_valid_ff;
   logic                   s2_valid_in;
   pbu_pkg::rsp_data_type  s2_data_ff;
   pbu_pkg::rsp_data_type  s2_data_in;

   logic                   s2_free;     // result register can take a new value
   logic                   s1_advance;  // stage 1 request moves into the result register
   logic                   req_take;    // request accepted this cycle

   // result register frees when empty or when the consumer takes it
   assign s2_free    = !s2_valid_ff || rsp_chan.ready;
   assign s1_advance = s1_valid_ff && s2_free;
   assign req_chan.ready = !s1_valid_ff || s2_free;
   assign req_take   = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_data_in.action  = req_chan.action;
      s1_data_in.a_red   = req_chan.a_red;
      s1_data_in.a_green = req_chan.a_green;
      s1_data_in.a_blue  = req_chan.a_blue;
      s1_data_in.b_red   = req_chan.b_red;
      s1_data_in.b_green = req_chan.b_green;
      s1_data_in.b_blue  = req_chan.b_blue;
      s1_valid_in        = req_take || (s1_valid_ff && !s2_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload loads on accept only, so a stalled request holds
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= s1_data_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Blend arithmetic
   // ---------------------------------------------------------------------------
   logic [9:0] gray_sum;
   logic [7:0] gray;

   // round((r+g+b)/3) = floor((r+g+b+1)/3)
   assign gray_sum = 10'(s1_data_ff.a_red) + 10'(s1_data_ff.a_green)
                   + 10'(s1_data_ff.a_blue) + 10'd1;
   assign gray     = pbu_pkg::div3(gray_sum);

   always_comb begin
      unique case (s1_data_ff.action)
         pbu_pkg::ACT_GRAYSCALE: begin
            s2_data_in.out_red   = gray;
            s2_data_in.out_green = gray;
            s2_data_in.out_blue  = gray;
         end
         pbu_pkg::ACT_SEPIA: begin
            // every channel from the original a pixel
            s2_data_in.out_red   = pbu_pkg::sepia_ch(s1_data_ff.a_red, s1_data_ff.a_green,
                                      s1_data_ff.a_blue, pbu_pkg::SEPIA_RR,
                                      pbu_pkg::SEPIA_RG, pbu_pkg::SEPIA_RB);
            s2_data_in.out_green = pbu_pkg::sepia_ch(s1_data_ff.a_red, s1_data_ff.a_green,
                                      s1_data_ff.a_blue, pbu_pkg::SEPIA_GR,
                                      pbu_pkg::SEPIA_GG, pbu_pkg::SEPIA_GB);
            s2_data_in.out_blue  = pbu_pkg::sepia_ch(s1_data_ff.a_red, s1_data_ff.a_green,
                                      s1_data_ff.a_blue, pbu_pkg::SEPIA_BR,
                                      pbu_pkg::SEPIA_BG, pbu_pkg::SEPIA_BB);
         end
         default: begin
            s2_data_in.out_red   = pbu_pkg::blend_ch(s1_data_ff.action, s1_data_ff.a_red,
                                                     s1_data_ff.b_red);
            s2_data_in.out_green = pbu_pkg::blend_ch(s1_data_ff.action, s1_data_ff.a_green,
                                                     s1_data_ff.b_green);
            s2_data_in.out_blue  = pbu_pkg::blend_ch(s1_data_ff.action, s1_data_ff.a_blue,
                                                     s1_data_ff.b_blue);
         end
      endcase
      s2_valid_in = s1_advance || (s2_valid_ff && !rsp_chan.ready);
   end

   // ---------------------------------------------------------------------------
   // Stage 2: result register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign rsp_chan.valid     = s2_valid_ff;
   assign rsp_chan.out_red   = s2_data_ff.out_red;
   assign rsp_chan.out_green = s2_data_ff.out_green;
   assign rsp_chan.out_blue  = s2_data_ff.out_blue;

`ifndef SYNTH
   // an accepted request is in the input register next cycle
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted request missing from input register");

   // an empty result register never blocks the request side
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s2_valid_ff |-> req_chan.ready)
      else $error("request stalled with empty result register");

   // nothing valid right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !s2_valid_ff))
      else $error("valid flag set after reset");

   // invert result tracks the stage 1 pixel
   a_invert: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && (s1_data_ff.action == pbu_pkg::ACT_INVERT))
      |=> (rsp_chan.out_red == ~$past(s1_data_ff.a_red)))
      else $error("invert result mismatch");
`endif

endmodule
